@@ src/wrm_pkg.sv @@
// ============================================================================
// wrm_pkg
// Shared types, codes and helpers for the windowed event rate meter.
// ============================================================================
package wrm_pkg;

    // Field widths fixed by the interface.
    localparam int TIME_WIDTH      = 32;
    localparam int COUNT_IN_WIDTH  = 32;
    localparam int RATE_WIDTH      = 64;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int CFG_INDEX_WIDTH = 2;

    // Defaults for the top-level parameters.
    localparam int COUNT_WIDTH_DEFAULT = 64;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // The divider produces one quotient bit per cycle.
    localparam int DIV_STEPS     = RATE_WIDTH;
    localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS);

    // Register reset values.
    localparam logic [TIME_WIDTH-1:0] START_TIME_RESET   = 32'd0;
    localparam logic [TIME_WIDTH-1:0] SHORT_WINDOW_RESET = 32'd3600;
    localparam logic [TIME_WIDTH-1:0] LONG_WINDOW_RESET  = 32'd86400;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_TIME   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHORT_WINDOW = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_WINDOW  = 2'd2;

    // Operation codes of an input word.
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // Window indexes.
    localparam int WINDOWS = 3;
    localparam logic [1:0] WIN_SHORT = 2'd0;
    localparam logic [1:0] WIN_LONG  = 2'd1;
    localparam logic [1:0] WIN_TOTAL = 2'd2;

    // Input word.
    typedef struct packed {
        logic                      operation;
        logic [COUNT_IN_WIDTH-1:0] event_count;
        logic [TIME_WIDTH-1:0]     now_seconds;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic [RATE_WIDTH-1:0] short_rate;
        logic [RATE_WIDTH-1:0] long_rate;
        logic [RATE_WIDTH-1:0] total_rate;
    } out_word_t;

    // Configuration register file contents.
    typedef struct packed {
        logic [TIME_WIDTH-1:0] start_time;
        logic [TIME_WIDTH-1:0] short_window_seconds;
        logic [TIME_WIDTH-1:0] long_window_seconds;
    } cfg_t;

    // Absolute difference of two times, so a clock running backwards counts forward.
    function automatic logic [TIME_WIDTH-1:0] abs_diff(
        input logic [TIME_WIDTH-1:0] a,
        input logic [TIME_WIDTH-1:0] b
    );
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

@@ src/windowed_event_rate_meter_top.sv @@
// ============================================================================
// windowed_event_rate_meter_top
// Event rate meter: counts events and, on request, reports the rates over
// a short window, a long window and since start.
//
//   Channel  Direction  Handshake              Word
//   evt      in         evt_valid / evt_stall  in_word_t  (add or update)
//   rate     out        rate_valid / rate_stall out_word_t (three rates)
//   cfg      in         cfg_write              cfg_index, cfg_data
//
// An add word is taken every cycle. An update leaves the queue, then each
// window in turn passes the prep, multiply-low, multiply-high, adjust and
// sum states and the one-bit-per-cycle divider (64 steps, then the quotient
// is handed over); the result is loaded once the output register is free.
// A window whose sum is negative skips the divider.
// Up to QUEUE_DEPTH updates wait in the queue; adds keep flowing meanwhile.
// evt_stall rises only for an update word while the queue is full.
// Reset clears all counters and window state at once; no clearing pass.
// ============================================================================
module windowed_event_rate_meter_top #(
    parameter int COUNT_WIDTH = wrm_pkg::COUNT_WIDTH_DEFAULT,
    parameter int QUEUE_DEPTH = wrm_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   evt_valid,
    output logic                                   evt_stall,
    input  wrm_pkg::in_word_t                      evt_word,
    output logic                                   rate_valid,
    input  logic                                   rate_stall,
    output wrm_pkg::out_word_t                     rate_word,
    input  logic                                   cfg_write,
    input  logic [wrm_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [wrm_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);

    localparam int ENTRY_WIDTH = wrm_pkg::TIME_WIDTH + COUNT_WIDTH;

    wrm_pkg::cfg_t          cfg_reg;
    logic                   q_push;
    logic                   q_pop;
    logic                   q_full;
    logic                   q_empty;
    logic [ENTRY_WIDTH-1:0] q_wr_data;
    logic [ENTRY_WIDTH-1:0] q_rd_data;

    // Configuration registers; an index past the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_time           <= wrm_pkg::START_TIME_RESET;
            cfg_reg.short_window_seconds <= wrm_pkg::SHORT_WINDOW_RESET;
            cfg_reg.long_window_seconds  <= wrm_pkg::LONG_WINDOW_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                wrm_pkg::REG_START_TIME:   cfg_reg.start_time           <= cfg_data;
                wrm_pkg::REG_SHORT_WINDOW: cfg_reg.short_window_seconds <= cfg_data;
                wrm_pkg::REG_LONG_WINDOW:  cfg_reg.long_window_seconds  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Front end: event total and update snapshots.
    wrm_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt_word  (evt_word),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_wr_data)
    );

    // Queue of pending updates.
    wrm_queue #(
        .WIDTH (ENTRY_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wr_data),
        .pop       (q_pop),
        .head_data (q_rd_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Back end: window refresh and result register.
    wrm_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_empty    (q_empty),
        .q_data     (q_rd_data),
        .q_pop      (q_pop),
        .rate_valid (rate_valid),
        .rate_stall (rate_stall),
        .rate_word  (rate_word)
    );

endmodule

@@ src/wrm_queue.sv @@
// ============================================================================
// wrm_queue
// Short register queue that carries pending update requests from the
// front end to the back end.
// ============================================================================
module wrm_queue #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_WIDTH = $clog2(DEPTH);
    localparam int CNT_WIDTH = $clog2(DEPTH + 1);
    localparam logic [PTR_WIDTH-1:0] LAST_PTR = PTR_WIDTH'(DEPTH - 1);
    localparam logic [CNT_WIDTH-1:0] FULL_CNT = CNT_WIDTH'(DEPTH);

    logic [WIDTH-1:0]     slot_reg [DEPTH];
    logic [PTR_WIDTH-1:0] wr_ptr_reg;
    logic [PTR_WIDTH-1:0] rd_ptr_reg;
    logic [CNT_WIDTH-1:0] count_reg;

    assign full      = (count_reg == FULL_CNT);
    assign empty     = (count_reg == '0);
    assign head_data = slot_reg[rd_ptr_reg];

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // A push lands on a full queue only together with a pop, and a pop never drains an empty one.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue pop while empty");

endmodule

@@ src/wrm_front.sv @@
// ============================================================================
// wrm_front
// Front end: accepts input words, keeps the running event total and queues
// each update request together with a snapshot of that total.
// ============================================================================
module wrm_front #(
    parameter int COUNT_WIDTH = wrm_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     evt_valid,
    output logic                                     evt_stall,
    input  wrm_pkg::in_word_t                        evt_word,
    input  logic                                     q_full,
    output logic                                     q_push,
    output logic [wrm_pkg::TIME_WIDTH+COUNT_WIDTH-1:0] q_data
);

    logic [COUNT_WIDTH-1:0] total_reg;
    logic [COUNT_WIDTH-1:0] total_next;
    logic                   is_update;
    logic                   accept;

    // Only an update needs room in the queue; adds are taken every cycle.
    assign is_update = (evt_word.operation == wrm_pkg::OP_UPDATE);
    assign evt_stall = evt_valid && is_update && q_full;
    assign accept    = evt_valid && !evt_stall;
    assign q_push    = accept && is_update;
    assign q_data    = {evt_word.now_seconds, total_reg};

    // The total wraps at the counter width.
    assign total_next = total_reg + COUNT_WIDTH'(evt_word.event_count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else if (accept && !is_update)
        begin
            total_reg <= total_next;
        end
    end

endmodule

@@ src/wrm_div.sv @@
// ============================================================================
// wrm_div
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit
// per cycle.
// ============================================================================
module wrm_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [wrm_pkg::RATE_WIDTH-1:0]     dividend,
    input  logic [wrm_pkg::TIME_WIDTH-1:0]     divisor,
    output logic                               busy,
    output logic                               done,
    output logic [wrm_pkg::RATE_WIDTH-1:0]     quotient
);

    localparam logic [wrm_pkg::DIV_CNT_WIDTH-1:0] LAST_STEP =
        wrm_pkg::DIV_CNT_WIDTH'(wrm_pkg::DIV_STEPS - 1);

    logic [wrm_pkg::TIME_WIDTH-1:0]    divisor_reg;
    logic [wrm_pkg::TIME_WIDTH-1:0]    rem_reg;
    logic [wrm_pkg::RATE_WIDTH-1:0]    quo_reg;
    logic [wrm_pkg::DIV_CNT_WIDTH-1:0] cnt_reg;
    logic                              busy_reg;
    logic                              done_reg;
    logic [wrm_pkg::TIME_WIDTH:0]      trial;
    logic [wrm_pkg::TIME_WIDTH:0]      diff;
    logic                              fits;

    // One restoring step: shift in the next dividend bit and try to subtract.
    assign trial = {rem_reg, quo_reg[wrm_pkg::RATE_WIDTH-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign fits  = (trial >= {1'b0, divisor_reg});

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
            rem_reg     <= '0;
            quo_reg     <= '0;
            divisor_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg    <= 1'b1;
                cnt_reg     <= '0;
                rem_reg     <= '0;
                quo_reg     <= dividend;
                divisor_reg <= divisor;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? diff[wrm_pkg::TIME_WIDTH-1:0]
                                : trial[wrm_pkg::TIME_WIDTH-1:0];
                quo_reg <= {quo_reg[wrm_pkg::RATE_WIDTH-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

@@ src/wrm_back.sv @@
// ============================================================================
// wrm_back
// Back end: takes queued update requests and refreshes the short, long and
// since-start windows one after another, then presents the three rates.
// ============================================================================
module wrm_back #(
    parameter int COUNT_WIDTH = wrm_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  wrm_pkg::cfg_t                              cfg,
    input  logic                                       q_empty,
    input  logic [wrm_pkg::TIME_WIDTH+COUNT_WIDTH-1:0] q_data,
    output logic                                       q_pop,
    output logic                                       rate_valid,
    input  logic                                       rate_stall,
    output wrm_pkg::out_word_t                         rate_word
);

    localparam int TW = wrm_pkg::TIME_WIDTH;
    localparam int RW = wrm_pkg::RATE_WIDTH;
    localparam int HW = RW / 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MUL_LO,
        S_MUL_HI,
        S_ADJ,
        S_SUM,
        S_DIV,
        S_OUT
    } state_t;

    state_t                 state_reg;
    logic [1:0]             win_reg;
    logic [TW-1:0]          now_reg;
    logic [COUNT_WIDTH-1:0] snap_reg;
    logic [TW-1:0]          divisor_reg;
    logic [TW-1:0]          since_reg;
    logic [RW-1:0]          fresh_reg;
    logic [RW-1:0]          prod_lo_reg;
    logic [HW-1:0]          prod_hi_reg;
    logic                   out_valid_reg;
    wrm_pkg::out_word_t     out_word_reg;

    // Per-window state.
    logic [COUNT_WIDTH-1:0] last_total_reg [wrm_pkg::WINDOWS];
    logic [RW-1:0]          sum_reg        [wrm_pkg::WINDOWS];
    logic [RW-1:0]          avg_reg        [wrm_pkg::WINDOWS];
    logic [TW-1:0]          last_upd_reg   [wrm_pkg::WINDOWS];

    logic [TW-1:0]          elapsed;
    logic [TW-1:0]          length;
    logic                   filling;
    logic [TW-1:0]          divisor_next;
    logic [COUNT_WIDTH-1:0] delta;
    logic [RW-1:0]          avg_cur;
    logic [RW-1:0]          mul_lo;
    logic [RW-1:0]          mul_hi;
    logic [RW-1:0]          sum_next;
    logic                   out_free;
    logic                   div_start;
    logic                   div_busy;
    logic                   div_done;
    logic [RW-1:0]          div_quotient;

    // Window setup: elapsed time, fill status and divisor.
    assign elapsed = wrm_pkg::abs_diff(now_reg, cfg.start_time);
    assign length  = (win_reg == wrm_pkg::WIN_SHORT) ? cfg.short_window_seconds
                                                     : cfg.long_window_seconds;
    assign filling = (win_reg == wrm_pkg::WIN_TOTAL) || (elapsed <= length);
    always_comb
    begin
        divisor_next = filling ? elapsed : length;
        if (divisor_next == '0)
        begin
            divisor_next = TW'(1);
        end
    end

    // Events since this window's last update, modulo the counter width.
    assign delta   = snap_reg - last_total_reg[win_reg];
    assign avg_cur = avg_reg[win_reg];

    // The decay product average * since is built from two 32x32 halves.
    assign mul_lo = avg_cur[HW-1:0] * since_reg;
    assign mul_hi = avg_cur[RW-1:HW] * since_reg;

    assign sum_next = sum_reg[win_reg] + fresh_reg;

    assign q_pop      = (state_reg == S_IDLE) && !q_empty;
    assign div_start  = (state_reg == S_SUM) && !sum_next[RW-1];
    assign out_free   = !out_valid_reg || !rate_stall;
    assign rate_valid = out_valid_reg;
    assign rate_word  = out_word_reg;

    wrm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (divisor_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Sequencer, window state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            win_reg       <= wrm_pkg::WIN_SHORT;
            now_reg       <= '0;
            snap_reg      <= '0;
            divisor_reg   <= '0;
            since_reg     <= '0;
            fresh_reg     <= '0;
            prod_lo_reg   <= '0;
            prod_hi_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
            for (int i = 0; i < wrm_pkg::WINDOWS; i++)
            begin
                last_total_reg[i] <= '0;
                sum_reg[i]        <= '0;
                avg_reg[i]        <= '0;
                last_upd_reg[i]   <= '0;
            end
        end
        else
        begin
            // The output state loads the register itself; elsewhere a taken word leaves.
            if (out_valid_reg && !rate_stall && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        now_reg   <= q_data[TW+COUNT_WIDTH-1:COUNT_WIDTH];
                        snap_reg  <= q_data[COUNT_WIDTH-1:0];
                        win_reg   <= wrm_pkg::WIN_SHORT;
                        state_reg <= S_PREP;
                    end
                end

                S_PREP:
                begin
                    // A window still filling takes no decay, so its product is zero.
                    divisor_reg              <= divisor_next;
                    fresh_reg                <= RW'(delta);
                    since_reg                <= filling ? '0
                        : wrm_pkg::abs_diff(now_reg, last_upd_reg[win_reg]);
                    last_total_reg[win_reg]  <= snap_reg;
                    last_upd_reg[win_reg]    <= now_reg;
                    state_reg                <= S_MUL_LO;
                end

                S_MUL_LO:
                begin
                    prod_lo_reg <= mul_lo;
                    state_reg   <= S_MUL_HI;
                end

                S_MUL_HI:
                begin
                    prod_hi_reg <= mul_hi[HW-1:0];
                    fresh_reg   <= fresh_reg - prod_lo_reg;
                    state_reg   <= S_ADJ;
                end

                S_ADJ:
                begin
                    fresh_reg <= fresh_reg - {prod_hi_reg, {HW{1'b0}}};
                    state_reg <= S_SUM;
                end

                S_SUM:
                begin
                    sum_reg[win_reg] <= sum_next;
                    if (sum_next[RW-1])
                    begin
                        // A negative sum reads as a zero rate.
                        avg_reg[win_reg] <= '0;
                        if (win_reg == wrm_pkg::WIN_TOTAL)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            win_reg   <= win_reg + 1'b1;
                            state_reg <= S_PREP;
                        end
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end

                S_DIV:
                begin
                    if (div_done)
                    begin
                        avg_reg[win_reg] <= div_quotient;
                        if (win_reg == wrm_pkg::WIN_TOTAL)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            win_reg   <= win_reg + 1'b1;
                            state_reg <= S_PREP;
                        end
                    end
                end

                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_word_reg.short_rate <= avg_reg[wrm_pkg::WIN_SHORT];
                        out_word_reg.long_rate  <= avg_reg[wrm_pkg::WIN_LONG];
                        out_word_reg.total_rate <= avg_reg[wrm_pkg::WIN_TOTAL];
                        out_valid_reg           <= 1'b1;
                        state_reg               <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The divider is only started when it is free.
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // A quotient only arrives while the sequencer waits for it.
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the wait state");

    // The window index never passes the since-start window.
    a_win_range: assert property (@(posedge clk) disable iff (!rst_n)
        win_reg != 2'd3)
        else $error("window index out of range");

    // A new result is loaded only when the previous one has gone or is leaving.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_valid_reg && rate_stall) |=> (state_reg == S_OUT))
        else $error("result overwritten while stalled");

endmodule
